FILE: src/afmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afmt_pkg
// Shared types and codes for the allocation/free match tracker.
// ----------------------------------------------------------------------------
package afmt_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CntW    = 48;
  localparam int unsigned OutW    = 13;

  localparam logic [OpW-1:0] OpAlloc = 2'd0;
  localparam logic [OpW-1:0] OpFree  = 2'd1;
  localparam logic [OpW-1:0] OpEnd   = 2'd2;
  localparam logic [OpW-1:0] OpRead  = 2'd3;

  localparam logic [StatusW-1:0] StAlloc    = 3'd0;
  localparam logic [StatusW-1:0] StFreeOk   = 3'd1;
  localparam logic [StatusW-1:0] StBadFree  = 3'd2;
  localparam logic [StatusW-1:0] StFull     = 3'd3;
  localparam logic [StatusW-1:0] StReport   = 3'd4;

  localparam logic [63:0] HashMult = 64'h61C8864680B583EB;

  localparam logic [CntW-1:0] Cnt48Max = {CntW{1'b1}};
  localparam logic [OutW-1:0] Cnt13Max = {OutW{1'b1}};

endpackage
`default_nettype wire

FILE: src/afmt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afmt_front
// Accepts requests, hashes the address in two registered steps, and pushes
// opcode, address and bucket into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module afmt_front #(
  parameter int unsigned HASH_BITS    = 10,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [afmt_pkg::OpW-1:0]          opcode_i,
  input  wire logic [ADDRESS_BITS-1:0]           block_address_i,
  output logic                                   q_valid_o,
  input  wire logic                              q_pop_i,
  output logic [afmt_pkg::OpW-1:0]               q_op_o,
  output logic [ADDRESS_BITS-1:0]                q_addr_o,
  output logic [HASH_BITS-1:0]                   q_bkt_o
);

  localparam int unsigned Aw = ADDRESS_BITS;

  // hash stage: three 32x32 partial products, summed when the entry is pushed
  logic                   h_valid_q;
  logic [afmt_pkg::OpW-1:0] h_op_q;
  logic [Aw-1:0]          h_addr_q;
  logic [63:0]            p_ll_q;
  logic [31:0]            p_lh_q, p_hl_q;
  logic [63:0]            a64;
  logic [63:0]            prod;
  logic                   h_adv;

  // queue
  logic [1:0]             cnt_q;
  logic                   wp_q, rp_q;
  logic [afmt_pkg::OpW-1:0] qo_q [2];
  logic [Aw-1:0]          qa_q [2];
  logic [HASH_BITS-1:0]   qb_q [2];
  logic                   push;

  assign a64 = 64'(block_address_i);
  assign h_adv = !h_valid_q || (cnt_q != 2'd2) || q_pop_i;
  assign in_stall_o = !h_adv;
  assign push = h_valid_q && h_adv;
  assign prod = p_ll_q + {p_lh_q + p_hl_q, 32'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
    end else if (h_adv) begin
      h_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_adv && in_valid_i) begin
      h_op_q   <= opcode_i;
      h_addr_q <= block_address_i;
      p_ll_q   <= 64'(a64[31:0]) * 64'(afmt_pkg::HashMult[31:0]);
      p_lh_q   <= a64[31:0] * afmt_pkg::HashMult[63:32];
      p_hl_q   <= a64[63:32] * afmt_pkg::HashMult[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (q_pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      qo_q[wp_q] <= h_op_q;
      qa_q[wp_q] <= h_addr_q;
      qb_q[wp_q] <= prod[63 -: HASH_BITS];
    end
  end

  assign q_valid_o = cnt_q != 2'd0;
  assign q_op_o    = qo_q[rp_q];
  assign q_addr_o  = qa_q[rp_q];
  assign q_bkt_o   = qb_q[rp_q];

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q == 2'd2 && !q_pop_i |-> !push;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: src/afmt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afmt_back
// Bucket read, way match, write back, counters and result register. Table
// valid bits sit in a per-bucket memory, cleared by a sweep after reset/end.
// ----------------------------------------------------------------------------
module afmt_back #(
  parameter int unsigned HASH_BITS    = 10,
  parameter int unsigned WAYS         = 4,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              q_valid_i,
  output logic                                   q_pop_o,
  input  wire logic [afmt_pkg::OpW-1:0]          q_op_i,
  input  wire logic [ADDRESS_BITS-1:0]           q_addr_i,
  input  wire logic [HASH_BITS-1:0]              q_bkt_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [afmt_pkg::StatusW-1:0]           status_o,
  output logic [afmt_pkg::CntW-1:0]              alloc_count_o,
  output logic [afmt_pkg::OutW-1:0]              outstanding_count_o,
  output logic [afmt_pkg::CntW-1:0]              bad_free_count_o
);

  localparam int unsigned Buckets = 1 << HASH_BITS;
  localparam int unsigned Aw = ADDRESS_BITS;
  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SRead  = 2'd1;
  localparam logic [1:0] SClear = 2'd2;

  logic [1:0] st_q;
  logic [Aw-1:0] mem [Buckets][WAYS];
  logic [Aw-1:0] rd_q [WAYS];
  logic [WAYS-1:0] vld_q [Buckets];   // bucket valid bits
  logic [HASH_BITS-1:0] clr_q;

  logic [afmt_pkg::OpW-1:0] op_q;
  logic [Aw-1:0] addr_q;
  logic [HASH_BITS-1:0] bkt_q;
  logic [WAYS-1:0] rv_q;

  logic [afmt_pkg::CntW-1:0] ac_q, bc_q;
  logic [afmt_pkg::OutW-1:0] oc_q;
  logic ov_q;

  logic out_free;
  logic [WAYS-1:0] hit, emp;
  logic [WayW-1:0] hw, ew;
  logic any_hit, any_emp;

  logic [afmt_pkg::CntW-1:0] ac_d, bc_d;
  logic [afmt_pkg::OutW-1:0] oc_d;
  logic [afmt_pkg::StatusW-1:0] status_d;
  logic [WAYS-1:0] row_d;
  logic vld_we;
  logic [HASH_BITS-1:0] vld_wa;
  logic [WAYS-1:0] vld_wd;

  assign out_free = !ov_q || !out_stall_i;
  assign q_pop_o = (st_q == SIdle) && q_valid_i && out_free;

  always_comb begin
    hw = '0; ew = '0; any_hit = 1'b0; any_emp = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      hit[w] = rv_q[w] && (rd_q[w] == addr_q);
      emp[w] = !rv_q[w];
      if (hit[w]) begin hw = WayW'(w); any_hit = 1'b1; end
      if (emp[w]) begin ew = WayW'(w); any_emp = 1'b1; end
    end
  end

  always_comb begin
    ac_d = ac_q;
    oc_d = oc_q;
    bc_d = bc_q;
    status_d = afmt_pkg::StReport;
    row_d = rv_q;
    unique case (op_q)
      afmt_pkg::OpAlloc: begin
        if (any_emp) begin
          status_d = afmt_pkg::StAlloc;
          row_d[ew] = 1'b1;
          if (ac_q != afmt_pkg::Cnt48Max) ac_d = ac_q + 1'b1;
          if (oc_q != afmt_pkg::Cnt13Max) oc_d = oc_q + 1'b1;
        end else begin
          status_d = afmt_pkg::StFull;
        end
      end
      afmt_pkg::OpFree: begin
        if (any_hit) begin
          status_d = afmt_pkg::StFreeOk;
          row_d[hw] = 1'b0;
          if (oc_q != '0) oc_d = oc_q - 1'b1;
        end else begin
          status_d = afmt_pkg::StBadFree;
          if (bc_q != afmt_pkg::Cnt48Max) bc_d = bc_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign vld_we = (st_q == SRead) || (st_q == SClear);
  assign vld_wa = (st_q == SClear) ? clr_q : bkt_q;
  assign vld_wd = (st_q == SClear) ? '0 : row_d;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      op_q   <= q_op_i;
      addr_q <= q_addr_i;
      bkt_q  <= q_bkt_i;
      rv_q   <= vld_q[q_bkt_i];
      for (int w = 0; w < WAYS; w++) rd_q[w] <= mem[q_bkt_i][w];
    end
    if (st_q == SRead && op_q == afmt_pkg::OpAlloc && any_emp) begin
      mem[bkt_q][ew] <= addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_we) begin
      vld_q[vld_wa] <= vld_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClear;
      clr_q <= '0;
      ac_q <= '0; bc_q <= '0; oc_q <= '0;
      ov_q <= 1'b0;
      status_o <= '0;
      alloc_count_o <= '0;
      outstanding_count_o <= '0;
      bad_free_count_o <= '0;
    end else begin
      ov_q <= (st_q == SRead) || (ov_q && out_stall_i);
      unique case (st_q)
        SIdle: if (q_pop_o) st_q <= SRead;
        SRead: st_q <= (op_q == afmt_pkg::OpEnd) ? SClear : SIdle;
        SClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == HASH_BITS'(Buckets - 1)) st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
      if (st_q == SRead) begin
        status_o <= status_d;
        alloc_count_o <= ac_d;
        outstanding_count_o <= oc_d;
        bad_free_count_o <= bc_d;
        if (op_q == afmt_pkg::OpEnd) begin
          ac_q <= '0; bc_q <= '0; oc_q <= '0;
        end else begin
          ac_q <= ac_d; bc_q <= bc_d; oc_q <= oc_d;
        end
      end
    end
  end

  assign out_valid_o = ov_q;

  a_one_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == SRead |=> st_q != SRead) else $error("read state stuck");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
  a_pop_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !ov_q || !out_stall_i) else $error("pop without room");

endmodule
`default_nettype wire

FILE: src/alloc_free_match_tracker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alloc_free_match_tracker_core
// Tracks outstanding allocations in a hashed set-associative table.
// ----------------------------------------------------------------------------
// Path from request to result: hash, queue, resolve.
// The back end takes a new request only after the bucket read/write back of the last.
// End clears the table by a sweep over all 2^HASH_BITS buckets (1024); input stalls.
// Reset: counters zero, no result pending, table cleared by the same sweep.
module alloc_free_match_tracker_core #(
  parameter int unsigned HASH_BITS    = 10,
  parameter int unsigned WAYS         = 4,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [afmt_pkg::OpW-1:0]          opcode_i,
  input  wire logic [ADDRESS_BITS-1:0]           block_address_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [afmt_pkg::StatusW-1:0]           status_o,
  output logic [afmt_pkg::CntW-1:0]              alloc_count_o,
  output logic [afmt_pkg::OutW-1:0]              outstanding_count_o,
  output logic [afmt_pkg::CntW-1:0]              bad_free_count_o
);

  logic q_valid, q_pop;
  logic [afmt_pkg::OpW-1:0] q_op;
  logic [ADDRESS_BITS-1:0] q_addr;
  logic [HASH_BITS-1:0] q_bkt;

  afmt_front #(.HASH_BITS(HASH_BITS), .ADDRESS_BITS(ADDRESS_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .block_address_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_op_o(q_op), .q_addr_o(q_addr),
    .q_bkt_o(q_bkt)
  );

  afmt_back #(.HASH_BITS(HASH_BITS), .WAYS(WAYS),
              .ADDRESS_BITS(ADDRESS_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_op_i(q_op),
    .q_addr_i(q_addr), .q_bkt_i(q_bkt), .out_valid_o, .out_stall_i, .status_o,
    .alloc_count_o, .outstanding_count_o, .bad_free_count_o
  );

endmodule
`default_nettype wire

FILE: sim/tb_alloc_free_match_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alloc_free_match_tracker_core
// Self-checking bench for the allocation/free match tracker. A directed table
// covers reset, extremes, bad frees, full buckets, end and status reads; then
// random alloc/free/read/end traffic over a small address pool is scored against a
// behavioral copy of the bucket table and counters.
// ----------------------------------------------------------------------------
module tb_alloc_free_match_tracker_core;

  localparam int unsigned HashBits = 10;
  localparam int unsigned Ways     = 4;
  localparam int unsigned AddrW    = 48;
  localparam int unsigned Buckets  = 1 << HashBits;
  localparam int unsigned NumRand  = 1600;
  localparam longint      MaxCycles = 400000;

  typedef struct packed {
    logic [afmt_pkg::StatusW-1:0] status;
    logic [afmt_pkg::CntW-1:0]    allocs;
    logic [afmt_pkg::OutW-1:0]    outstanding;
    logic [afmt_pkg::CntW-1:0]    bad_frees;
  } tracker_result_t;

  typedef struct {
    logic [afmt_pkg::OpW-1:0] op;
    logic [AddrW-1:0]         addr;
    bit                       typed;
    tracker_result_t          want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [afmt_pkg::OpW-1:0] opcode_i = '0;
  logic [AddrW-1:0] block_address_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [afmt_pkg::StatusW-1:0] status_o;
  logic [afmt_pkg::CntW-1:0] alloc_count_o;
  logic [afmt_pkg::OutW-1:0] outstanding_count_o;
  logic [afmt_pkg::CntW-1:0] bad_free_count_o;

  alloc_free_match_tracker_core #(
    .HASH_BITS(HashBits), .WAYS(Ways), .ADDRESS_BITS(AddrW)
  ) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .block_address_i,
    .out_valid_o, .out_stall_i, .status_o, .alloc_count_o,
    .outstanding_count_o, .bad_free_count_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // behavioral copy of the tracker
  logic [AddrW-1:0]         way_addr[Buckets][Ways];
  bit                       way_used[Buckets][Ways];
  logic [afmt_pkg::CntW-1:0] allocs_q;
  logic [afmt_pkg::OutW-1:0] outst_q;
  logic [afmt_pkg::CntW-1:0] bad_q;

  tracker_result_t pending_results[$];
  int  mismatches = 0;
  bit  quiet = 1'b0;
  longint cycles = 0;

  function automatic int unsigned bucket_index(logic [AddrW-1:0] a);
    logic [63:0] p;
    p = 64'(a) * afmt_pkg::HashMult;
    return int'(p >> (64 - HashBits));
  endfunction

  function automatic void clear_tracker();
    foreach (way_used[b, w]) begin
      way_used[b][w] = 1'b0;
      way_addr[b][w] = '0;
    end
    allocs_q = '0;
    outst_q = '0;
    bad_q = '0;
  endfunction

  function automatic tracker_result_t track_request(logic [afmt_pkg::OpW-1:0] op,
                                                    logic [AddrW-1:0] a);
    tracker_result_t r;
    int unsigned b;
    b = bucket_index(a);
    r.status = afmt_pkg::StReport;
    r.allocs = allocs_q;
    r.outstanding = outst_q;
    r.bad_frees = bad_q;
    if (op == afmt_pkg::OpAlloc) begin
      r.status = afmt_pkg::StFull;
      for (int w = 0; w < Ways; w++) begin
        if (!way_used[b][w]) begin
          way_used[b][w] = 1'b1;
          way_addr[b][w] = a;
          if (allocs_q != afmt_pkg::Cnt48Max) allocs_q++;
          if (outst_q != afmt_pkg::Cnt13Max) outst_q++;
          r.status = afmt_pkg::StAlloc;
          break;
        end
      end
    end else if (op == afmt_pkg::OpFree) begin
      r.status = afmt_pkg::StBadFree;
      for (int w = 0; w < Ways; w++) begin
        if (way_used[b][w] && way_addr[b][w] == a) begin
          way_used[b][w] = 1'b0;
          way_addr[b][w] = '0;
          if (outst_q != 0) outst_q--;
          r.status = afmt_pkg::StFreeOk;
          break;
        end
      end
      if (r.status == afmt_pkg::StBadFree && bad_q != afmt_pkg::Cnt48Max) bad_q++;
    end else begin
      if (op == afmt_pkg::OpEnd) clear_tracker();
      return r;
    end
    r.allocs = allocs_q;
    r.outstanding = outst_q;
    r.bad_frees = bad_q;
    return r;
  endfunction

  // random stall on the result side, with a quiet stretch
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 27);
  end

  always @(posedge clk_i) begin
    tracker_result_t got, exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status_o, alloc_count_o, outstanding_count_o, bad_free_count_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp = pending_results.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", exp, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > MaxCycles) begin
      $display("tb_alloc_free_match_tracker_core: FAIL");
      $finish;
    end
  end

  // drive one request; expectation queued at acceptance
  task automatic send_request(logic [afmt_pkg::OpW-1:0] op, logic [AddrW-1:0] a,
                              bit typed, tracker_result_t want);
    tracker_result_t r;
    while (!quiet && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    block_address_i <= a;
    do @(posedge clk_i); while (in_stall_o);
    r = track_request(op, a);
    if (typed && r !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("table row exp %p model %p", want, r);
    end
    pending_results.push_back(typed ? want : r);
  endtask

  function automatic logic [AddrW-1:0] rand_addr();
    return AddrW'({$urandom(), $urandom()});
  endfunction

  stim_row_t rows[$];
  logic [AddrW-1:0] pool[32];
  logic [AddrW-1:0] same_bkt[6];
  localparam logic [AddrW-1:0] AllOnes = {AddrW{1'b1}};

  initial begin
    stim_row_t s;
    int n;
    logic [AddrW-1:0] a;
    clear_tracker();
    // addresses that share the bucket of address 1
    n = 0;
    a = 48'h2;
    while (n < 6) begin
      if (bucket_index(a) == bucket_index(48'h1)) begin
        same_bkt[n] = a;
        n++;
      end
      a++;
    end
    rows = '{
      '{afmt_pkg::OpRead,  48'h0,   1'b1, '{afmt_pkg::StReport, 48'd0, 13'd0, 48'd0}},
      '{afmt_pkg::OpFree,  48'h0,   1'b1, '{afmt_pkg::StBadFree, 48'd0, 13'd0, 48'd1}},
      '{afmt_pkg::OpAlloc, 48'h0,   1'b1, '{afmt_pkg::StAlloc, 48'd1, 13'd1, 48'd1}},
      '{afmt_pkg::OpAlloc, AllOnes, 1'b1, '{afmt_pkg::StAlloc, 48'd2, 13'd2, 48'd1}},
      '{afmt_pkg::OpAlloc, AllOnes, 1'b1, '{afmt_pkg::StAlloc, 48'd3, 13'd3, 48'd1}},
      '{afmt_pkg::OpFree,  AllOnes, 1'b1, '{afmt_pkg::StFreeOk, 48'd3, 13'd2, 48'd1}},
      '{afmt_pkg::OpFree,  48'h0,   1'b1, '{afmt_pkg::StFreeOk, 48'd3, 13'd1, 48'd1}},
      '{afmt_pkg::OpFree,  48'h0,   1'b1, '{afmt_pkg::StBadFree, 48'd3, 13'd1, 48'd2}},
      '{afmt_pkg::OpAlloc, 48'h1,   1'b0, '{default: '0}},
      '{afmt_pkg::OpAlloc, same_bkt[0], 1'b0, '{default: '0}},
      '{afmt_pkg::OpAlloc, same_bkt[1], 1'b0, '{default: '0}},
      '{afmt_pkg::OpAlloc, same_bkt[2], 1'b0, '{default: '0}},
      '{afmt_pkg::OpAlloc, same_bkt[3], 1'b0, '{default: '0}},
      '{afmt_pkg::OpFree,  same_bkt[4], 1'b0, '{default: '0}},
      '{afmt_pkg::OpFree,  same_bkt[1], 1'b0, '{default: '0}},
      '{afmt_pkg::OpAlloc, same_bkt[5], 1'b0, '{default: '0}},
      '{afmt_pkg::OpRead,  48'h5,   1'b1, '{afmt_pkg::StReport, 48'd8, 13'd5, 48'd3}},
      '{afmt_pkg::OpEnd,   AllOnes, 1'b1, '{afmt_pkg::StReport, 48'd8, 13'd5, 48'd3}},
      '{afmt_pkg::OpRead,  48'h0,   1'b1, '{afmt_pkg::StReport, 48'd0, 13'd0, 48'd0}},
      '{afmt_pkg::OpFree,  48'h1,   1'b1, '{afmt_pkg::StBadFree, 48'd0, 13'd0, 48'd1}},
      '{afmt_pkg::OpEnd,   48'h0,   1'b1, '{afmt_pkg::StReport, 48'd0, 13'd0, 48'd1}}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      s = rows[i];
      send_request(s.op, s.addr, s.typed, s.want);
    end
    foreach (pool[i]) pool[i] = (i < 8) ? same_bkt[i % 6] : rand_addr();
    for (int i = 0; i < NumRand; i++) begin
      logic [afmt_pkg::OpW-1:0] op;
      int unsigned r;
      quiet = (i >= 600 && i < 800);
      r = $urandom_range(99);
      if (r < 45) op = afmt_pkg::OpAlloc;
      else if (r < 90) op = afmt_pkg::OpFree;
      else if (r < 95) op = afmt_pkg::OpRead;
      else op = afmt_pkg::OpEnd;
      a = ($urandom_range(9) == 0) ? rand_addr() : pool[$urandom_range(31)];
      if (i % 200 == 0) pool[$urandom_range(31)] = rand_addr();
      send_request(op, a, 1'b0, '{default: '0});
    end
    in_valid_i <= 1'b0;
    quiet = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_alloc_free_match_tracker_core: PASS");
    end else begin
      $display("tb_alloc_free_match_tracker_core: FAIL");
    end
    $finish;
  end
endmodule
